// ----- hw/rtl/ilr_pkg.sv -----
package ilr_pkg;

    // Default geometry of the list
    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned WIDTH_DEF = 32;

    // Operation codes carried in the action field
    typedef enum logic [2:0] {
        ACT_GET            = 3'd0,
        ACT_SET            = 3'd1,
        ACT_APPEND         = 3'd2,
        ACT_INSERT         = 3'd3,
        ACT_REMOVE_ORDERED = 3'd4,
        ACT_REMOVE_SWAP    = 3'd5,
        ACT_POP            = 3'd6,
        ACT_CLEAR          = 3'd7
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast control to every cell of the row
    typedef struct packed {
        logic    en;   // operation passed its checks and updates the list
        t_action act;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/ilr_op_if.sv -----
// Operation channel: one item is one list operation
interface ilr_op_if #(
    parameter int unsigned IW = 5,
    parameter int unsigned WIDTH = ilr_pkg::WIDTH_DEF
);
    logic             valid;
    logic             ready;
    logic [2:0]       action;
    logic [IW-1:0]    index;
    logic [WIDTH-1:0] value;

    modport source (output valid, output action, output index, output value, input ready);
    modport sink   (input valid, input action, input index, input value, output ready);
endinterface

// ----- hw/rtl/ilr_res_if.sv -----
// Result channel: one item per operation
interface ilr_res_if #(
    parameter int unsigned CW = 5,
    parameter int unsigned WIDTH = ilr_pkg::WIDTH_DEF
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] read_value;
    logic [CW-1:0]    length;
    logic [1:0]       status;

    modport source (output valid, output read_value, output length, output status, input ready);
    modport sink   (input valid, input read_value, input length, input status, output ready);
endinterface

// ----- hw/rtl/ilr_cell.sv -----
// One list entry; decides its own move from the broadcast operation
module ilr_cell #(
    parameter int unsigned POS   = 0,
    parameter int unsigned DEPTH = ilr_pkg::DEPTH_DEF,
    parameter int unsigned WIDTH = ilr_pkg::WIDTH_DEF
) (
    input  logic                         i_clk,
    input  ilr_pkg::t_cell_ctl           i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]   i_idx,
    input  logic [$clog2(DEPTH+1)-1:0]   i_cnt,
    input  logic [WIDTH-1:0]             i_value,
    input  logic [WIDTH-1:0]             i_lo,    // entry below (shift up source)
    input  logic [WIDTH-1:0]             i_hi,    // entry above (shift down source)
    input  logic [WIDTH-1:0]             i_last,  // last live entry (swap source)
    output logic [WIDTH-1:0]             o_data
);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] P  = (CW + 1)'(POS);

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;
    logic [CW:0]      idx_x;
    logic [CW:0]      cnt_x;

    assign idx_x = {1'b0, i_idx};
    assign cnt_x = {1'b0, i_cnt};

    // Per-cell move select
    always_comb begin
        n_data = r_data;
        if (i_ctl.en) begin
            case (i_ctl.act)
                ilr_pkg::ACT_SET: begin
                    if (P == idx_x) n_data = i_value;
                end
                ilr_pkg::ACT_APPEND: begin
                    if (P == cnt_x) n_data = i_value;
                end
                ilr_pkg::ACT_INSERT: begin
                    if (P == idx_x) n_data = i_value;
                    else if (P > idx_x && P <= cnt_x) n_data = i_lo;
                end
                ilr_pkg::ACT_REMOVE_ORDERED: begin
                    if (P >= idx_x && (P + 1'b1) < cnt_x) n_data = i_hi;
                end
                ilr_pkg::ACT_REMOVE_SWAP, ilr_pkg::ACT_POP: begin
                    if (P == idx_x) n_data = i_last;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

// ----- hw/rtl/ilr_sel.sv -----
// Picks one entry of the cell row by position
module ilr_sel #(
    parameter int unsigned DEPTH = ilr_pkg::DEPTH_DEF,
    parameter int unsigned WIDTH = ilr_pkg::WIDTH_DEF
) (
    input  logic [WIDTH-1:0]           i_words [DEPTH],
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    output logic [WIDTH-1:0]           o_word
);
    always_comb begin
        o_word = i_words[i_addr];
    end
endmodule

// ----- hw/rtl/indexed_list_insert_remove_engine_core.sv -----
// Ordered list of up to DEPTH words held in a row of cells, one entry per cell.
// Each operation item is executed in the cycle it is accepted: insert and ordered
// remove shift every affected cell by one place at once, so one item is taken
// per clock and its result item appears in the output register in the next cycle.
// The operation channel is ready whenever that register is empty or is being
// drained in the same cycle, so a stalled result channel stops input only once
// its register is full. The entries need no clearing after reset; only the
// length is cleared, and entries at or above the length are never read.
module indexed_list_insert_remove_engine_core #(
    parameter int unsigned DEPTH = ilr_pkg::DEPTH_DEF,
    parameter int unsigned WIDTH = ilr_pkg::WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilr_op_if.sink     i_op,
    ilr_res_if.source  o_res
);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned LW = $clog2(DEPTH);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    ilr_pkg::t_action   act;
    ilr_pkg::t_cell_ctl ctl;
    ilr_pkg::t_status   r_status, n_status;
    logic [CW-1:0]      r_cnt, n_cnt, r_len;
    logic [CW-1:0]      cnt_m1;
    logic [WIDTH-1:0]   r_rd, n_rd;
    logic               r_valid;
    logic               in_fire;
    logic               in_range;
    logic               full;
    logic               upd;
    logic [WIDTH-1:0]   w_data [DEPTH];
    logic [WIDTH-1:0]   w_rd;
    logic [WIDTH-1:0]   w_last;

    assign i_op.ready = !r_valid || o_res.ready;
    assign in_fire    = i_op.valid && i_op.ready;
    assign act        = ilr_pkg::t_action'(i_op.action);
    assign in_range   = i_op.index < r_cnt;
    assign full       = r_cnt == FullCnt;
    assign cnt_m1     = r_cnt - 1'b1;

    // Operation checks, new length and read word
    always_comb begin
        n_status = ilr_pkg::ST_OK;
        n_cnt    = r_cnt;
        n_rd     = '0;
        upd      = 1'b0;
        case (act)
            ilr_pkg::ACT_GET: begin
                if (in_range) n_rd = w_rd;
                else n_status = ilr_pkg::ST_RANGE;
            end
            ilr_pkg::ACT_SET: begin
                if (in_range) upd = 1'b1;
                else n_status = ilr_pkg::ST_RANGE;
            end
            ilr_pkg::ACT_APPEND: begin
                if (full) begin
                    n_status = ilr_pkg::ST_FULL;
                end else begin
                    upd   = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ilr_pkg::ACT_INSERT: begin
                if (i_op.index > r_cnt) begin
                    n_status = ilr_pkg::ST_RANGE;
                end else if (full) begin
                    n_status = ilr_pkg::ST_FULL;
                end else begin
                    upd   = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ilr_pkg::ACT_REMOVE_ORDERED, ilr_pkg::ACT_REMOVE_SWAP, ilr_pkg::ACT_POP: begin
                if (in_range) begin
                    upd   = 1'b1;
                    n_cnt = cnt_m1;
                    if (act == ilr_pkg::ACT_POP) n_rd = w_rd;
                end else begin
                    n_status = ilr_pkg::ST_RANGE;
                end
            end
            ilr_pkg::ACT_CLEAR: begin
                n_cnt = '0;
            end
            default: ;
        endcase
    end

    assign ctl.en  = in_fire && upd;
    assign ctl.act = act;

    // Row of cells, each wired to its neighbors
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [WIDTH-1:0] lo;
        logic [WIDTH-1:0] hi;
        if (k == 0) begin : g_lo0
            assign lo = '0;
        end else begin : g_lo
            assign lo = w_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_hitop
            assign hi = '0;
        end else begin : g_hi
            assign hi = w_data[k+1];
        end
        ilr_cell #(.POS(k), .DEPTH(DEPTH), .WIDTH(WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_idx   (i_op.index),
            .i_cnt   (r_cnt),
            .i_value (i_op.value),
            .i_lo    (lo),
            .i_hi    (hi),
            .i_last  (w_last),
            .o_data  (w_data[k])
        );
    end

    // Read ports: indexed entry and last live entry
    ilr_sel #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_sel_rd (
        .i_words (w_data),
        .i_addr  (i_op.index[LW-1:0]),
        .o_word  (w_rd)
    );

    ilr_sel #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_sel_last (
        .i_words (w_data),
        .i_addr  (cnt_m1[LW-1:0]),
        .o_word  (w_last)
    );

    // Length and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (in_fire) r_cnt <= n_cnt;
            if (in_fire) r_valid <= 1'b1;
            else if (o_res.ready) r_valid <= 1'b0;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd     <= n_rd;
            r_len    <= n_cnt;
            r_status <= n_status;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.read_value = r_rd;
    assign o_res.length     = r_len;
    assign o_res.status     = r_status;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FullCnt)
        else $error("list length above capacity");

    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> $stable(r_cnt))
        else $error("length changed without an item");

    a_res_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_res.valid && o_res.length == r_cnt)
        else $error("result missing or length mismatch");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && act == ilr_pkg::ACT_CLEAR |=>
            o_res.length == '0 && o_res.status == ilr_pkg::ST_OK)
        else $error("clear did not empty the list");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status != ilr_pkg::ST_OK |-> o_res.read_value == '0)
        else $error("rejected item returned data");
`endif
endmodule
